>>> hdl/record_insertion_sorter_defines.svh
// Assertion macros shared by the record insertion sorter RTL.
// Depends on nothing; included by the top level only.
`ifndef RECORD_INSERTION_SORTER_DEFINES_SVH
`define RECORD_INSERTION_SORTER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RIS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record sorter check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record sorter check failed");

`endif

>>> hdl/ris_pkg.sv
// Package for the record insertion sorter: payload structs, record type,
// controller commands and state encoding. Depends on nothing.
`default_nettype none

package ris_pkg;

    localparam int MAX_ITEMS_DEFAULT = 16;

    typedef struct packed {
        logic [63:0] hash_word_0;
        logic [63:0] hash_word_1;
        logic [63:0] hash_word_2;
        logic [63:0] hash_word_3;
        logic [63:0] ref_word_0;
        logic [63:0] ref_word_1;
        logic [63:0] ref_word_2;
        logic [63:0] ref_word_3;
        logic [63:0] item_size;
        logic        last_item;
    } item_t;

    typedef struct packed {
        logic [63:0] out_hash_word_0;
        logic [63:0] out_hash_word_1;
        logic [63:0] out_hash_word_2;
        logic [63:0] out_hash_word_3;
        logic [63:0] out_ref_word_0;
        logic [63:0] out_ref_word_1;
        logic [63:0] out_ref_word_2;
        logic [63:0] out_ref_word_3;
        logic [63:0] out_size;
        logic        out_last;
        logic        overflow;
    } result_t;

    // Word 0 of the hash is the most significant part of the sort key, so a
    // plain unsigned compare of the packed record gives the required order.
    typedef struct packed {
        logic [63:0] hash_word_0;
        logic [63:0] hash_word_1;
        logic [63:0] hash_word_2;
        logic [63:0] hash_word_3;
        logic [63:0] ref_word_0;
        logic [63:0] ref_word_1;
        logic [63:0] ref_word_2;
        logic [63:0] ref_word_3;
        logic [63:0] item_size;
    } rec_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } ris_cmd_t;

    typedef struct packed {
        logic last_beat;
    } ris_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

`default_nettype wire

>>> hdl/record_insertion_sorter.sv
// Top level of the record insertion sorter: controller plus datapath.
// Depends on ris_pkg, ris_ctrl, ris_datapath and the assertion header.
//
// Usage: present a record on item and raise start; the beat is taken at a
// clock edge where start is high and busy is low. Each record is inserted
// into a sorted register array in the cycle it is taken, so loading runs at
// one record per cycle. Records beyond MAX_ITEMS are dropped and flagged.
// The record with last_item set starts the drain: from the next cycle busy
// is high and one sorted record per cycle appears on result with
// result_valid high, ascending, out_last on the final one and overflow on
// all of them if any record was dropped. Each drain beat shifts the stored
// records toward the array head; the next set may start in the cycle after
// out_last. The receiver cannot stall; each result is valid for exactly
// one cycle. Reset empties the array and clears the overflow flag; the
// array contents themselves are not reset.
`default_nettype none
`include "record_insertion_sorter_defines.svh"

module record_insertion_sorter
    import ris_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       result_valid,
    output result_t    result
);

    ris_cmd_t  cmd;
    ris_stat_t stat;

    ris_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (item.last_item),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    ris_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .stat   (stat),
        .result (result)
    );

    assign result_valid = cmd.shift;

    `RIS_ASSERT_NEXT(a_last_starts_drain, clk, rst_n, start && !busy && item.last_item, result_valid)
    `RIS_ASSERT_NEXT(a_drain_ends, clk, rst_n, result_valid && result.out_last, !result_valid)
    `RIS_ASSERT_NEXT(a_drain_continues, clk, rst_n, result_valid && !result.out_last, result_valid)
    `RIS_ASSERT_SAME(a_valid_when_busy, clk, rst_n, result_valid, busy)

endmodule

`default_nettype wire

>>> hdl/ris_ctrl.sv
// Controller of the record insertion sorter: load and drain sequencing.
// Depends on ris_pkg.
`default_nettype none

module ris_ctrl
    import ris_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      last_item,
    input  wire ris_stat_t stat,
    output ris_cmd_t       cmd,
    output logic           busy
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_item)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.last_beat)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.insert = accept;
    assign cmd.shift  = (state_reg == ST_DRAIN);
    assign busy       = (state_reg == ST_DRAIN);

endmodule

`default_nettype wire

>>> hdl/ris_datapath.sv
// Datapath of the record insertion sorter: sorted record array with
// parallel compare-and-shift insertion and a drain shift. Depends on ris_pkg.
`default_nettype none

module ris_datapath
    import ris_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ris_cmd_t cmd,
    input  wire item_t    item,
    output ris_stat_t     stat,
    output result_t       result
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    rec_t                 store_reg  [MAX_ITEMS];
    rec_t                 store_next [MAX_ITEMS];
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 flag_reg;
    logic                 flag_next;
    logic [MAX_ITEMS-1:0] le;
    logic                 full;
    logic                 do_insert;
    rec_t                 new_rec;

    assign new_rec = {item.hash_word_0, item.hash_word_1, item.hash_word_2,
                      item.hash_word_3, item.ref_word_0, item.ref_word_1,
                      item.ref_word_2, item.ref_word_3, item.item_size};

    assign full      = (count_reg == CNT_W'(MAX_ITEMS));
    assign do_insert = cmd.insert && !full;

    genvar i;
    generate
        for (i = 0; i < MAX_ITEMS; i++)
        begin : g_slot
            assign le[i] = (count_reg > CNT_W'(i)) && !(store_reg[i] > new_rec);

            if (i == 0)
            begin : g_head
                always_comb
                begin
                    store_next[i] = store_reg[i];
                    if (cmd.shift)
                    begin
                        if (MAX_ITEMS > 1)
                        begin
                            store_next[i] = store_reg[(MAX_ITEMS > 1) ? 1 : 0];
                        end
                    end
                    else if (do_insert && !le[i])
                    begin
                        store_next[i] = new_rec;
                    end
                end
            end
            else
            begin : g_body
                always_comb
                begin
                    store_next[i] = store_reg[i];
                    if (cmd.shift)
                    begin
                        if (i < MAX_ITEMS - 1)
                        begin
                            store_next[i] = store_reg[(i < MAX_ITEMS - 1) ? i + 1 : i];
                        end
                    end
                    else if (do_insert && !le[i])
                    begin
                        store_next[i] = le[i-1] ? new_rec : store_reg[i-1];
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        flag_next  = flag_reg;
        if (cmd.shift)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                flag_next = 1'b0;
            end
        end
        else if (cmd.insert)
        begin
            if (full)
            begin
                flag_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

    assign stat.last_beat = (count_reg == CNT_W'(1));

    assign result.out_hash_word_0 = store_reg[0].hash_word_0;
    assign result.out_hash_word_1 = store_reg[0].hash_word_1;
    assign result.out_hash_word_2 = store_reg[0].hash_word_2;
    assign result.out_hash_word_3 = store_reg[0].hash_word_3;
    assign result.out_ref_word_0  = store_reg[0].ref_word_0;
    assign result.out_ref_word_1  = store_reg[0].ref_word_1;
    assign result.out_ref_word_2  = store_reg[0].ref_word_2;
    assign result.out_ref_word_3  = store_reg[0].ref_word_3;
    assign result.out_size        = store_reg[0].item_size;
    assign result.out_last        = (count_reg == CNT_W'(1));
    assign result.overflow        = flag_reg;

endmodule

`default_nettype wire

>>> bench/record_insertion_sorter_test.sv
// Self-checking testbench for record_insertion_sorter: loads record sets,
// predicts the stable sorted drain and compares every result beat.
// Depends on ris_pkg and the record_insertion_sorter RTL.
module record_insertion_sorter_test
    import ris_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SORT_DEPTH = MAX_ITEMS_DEFAULT;

    typedef struct {
        item_t rec;
        bit    drain_first;
    } pending_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    result_valid;
    result_t result;

    pending_t send_queue[$];
    item_t    stored_recs[$];
    result_t  sorted_expect[$];
    bit       set_dropped = 1'b0;
    int       accepted_count = 0;
    int       mismatch_count = 0;
    int       sets_drained = 0;
    int       results_checked = 0;
    int       overflow_sets = 0;

    record_insertion_sorter #(
        .MAX_ITEMS(SORT_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .result_valid(result_valid),
        .result(result)
    );

    always #2 clk = ~clk;

    function automatic logic [575:0] sort_key(input item_t r);
        return {r.hash_word_0, r.hash_word_1, r.hash_word_2, r.hash_word_3,
                r.ref_word_0, r.ref_word_1, r.ref_word_2, r.ref_word_3, r.item_size};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 64'd0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'($urandom_range(0, 3));
            default: return rand64();
        endcase
    endfunction

    function automatic item_t build_record(input logic [63:0] h0, h1, h2, h3,
                                           input logic [63:0] r0, r1, r2, r3,
                                           input logic [63:0] sz, input logic last);
        item_t r;
        r.hash_word_0 = h0;
        r.hash_word_1 = h1;
        r.hash_word_2 = h2;
        r.hash_word_3 = h3;
        r.ref_word_0 = r0;
        r.ref_word_1 = r1;
        r.ref_word_2 = r2;
        r.ref_word_3 = r3;
        r.item_size = sz;
        r.last_item = last;
        return r;
    endfunction

    task automatic queue_record(input item_t rec, input bit drain_first);
        pending_t p;
        p.rec = rec;
        p.drain_first = drain_first;
        send_queue.push_back(p);
    endtask

    // Stable insertion: the new record goes after every stored one not greater than it.
    task automatic take_record(input item_t rec);
        int      pos;
        result_t r;
        if (stored_recs.size() < SORT_DEPTH)
        begin
            pos = stored_recs.size();
            while (pos > 0 && sort_key(rec) < sort_key(stored_recs[pos - 1]))
                pos--;
            stored_recs.insert(pos, rec);
        end
        else
        begin
            set_dropped = 1'b1;
        end
        accepted_count++;
        if (rec.last_item)
        begin
            for (int k = 0; k < stored_recs.size(); k++)
            begin
                r.out_hash_word_0 = stored_recs[k].hash_word_0;
                r.out_hash_word_1 = stored_recs[k].hash_word_1;
                r.out_hash_word_2 = stored_recs[k].hash_word_2;
                r.out_hash_word_3 = stored_recs[k].hash_word_3;
                r.out_ref_word_0 = stored_recs[k].ref_word_0;
                r.out_ref_word_1 = stored_recs[k].ref_word_1;
                r.out_ref_word_2 = stored_recs[k].ref_word_2;
                r.out_ref_word_3 = stored_recs[k].ref_word_3;
                r.out_size = stored_recs[k].item_size;
                r.out_last = (k == stored_recs.size() - 1);
                r.overflow = set_dropped;
                sorted_expect.push_back(r);
            end
            sets_drained++;
            if (set_dropped)
                overflow_sets++;
            stored_recs.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (start && !busy)
                take_record(item);
            if (!start || !busy)
            begin
                if (send_queue.size() > 0
                    && !(send_queue[0].drain_first && sorted_expect.size() != 0)
                    && ((accepted_count >= 200 && accepted_count < 320)
                        || $urandom_range(0, 99) >= 23))
                begin
                    start <= 1'b1;
                    item <= send_queue[0].rec;
                    void'(send_queue.pop_front());
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (sorted_expect.size() == 0)
            begin
                $error("result beat with no expected record: %h", result);
                mismatch_count++;
            end
            else
            begin
                want = sorted_expect.pop_front();
                results_checked++;
                check_field("out_hash_word_0", want.out_hash_word_0, result.out_hash_word_0);
                check_field("out_hash_word_1", want.out_hash_word_1, result.out_hash_word_1);
                check_field("out_hash_word_2", want.out_hash_word_2, result.out_hash_word_2);
                check_field("out_hash_word_3", want.out_hash_word_3, result.out_hash_word_3);
                check_field("out_ref_word_0", want.out_ref_word_0, result.out_ref_word_0);
                check_field("out_ref_word_1", want.out_ref_word_1, result.out_ref_word_1);
                check_field("out_ref_word_2", want.out_ref_word_2, result.out_ref_word_2);
                check_field("out_ref_word_3", want.out_ref_word_3, result.out_ref_word_3);
                check_field("out_size", want.out_size, result.out_size);
                check_field("out_last", 64'(want.out_last), 64'(result.out_last));
                check_field("overflow", 64'(want.overflow), 64'(result.overflow));
            end
        end
    end

    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        item_t prev;
        int    random_items;
        int    set_len;
        int    set_index;
        logic [63:0] h0, h1, h2, h3, r0, r1, r2, r3;

        queue_record(build_record('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1), 1'b0);
        queue_record(build_record('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1), 1'b0);
        queue_record(build_record(5, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
        queue_record(build_record(0, 0, 0, '1, '1, '1, '1, '1, '1, 1'b0), 1'b0);
        queue_record(build_record(5, 0, 0, 0, 0, 0, 0, 1, 0, 1'b0), 1'b0);
        queue_record(build_record(5, 0, 0, 0, 0, 0, 0, 0, 7, 1'b0), 1'b0);
        queue_record(build_record(5, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b0);
        queue_record(build_record(64'h8000_0000_0000_0000, 0, 0, 0,
                                  rand64(), rand64(), rand64(), rand64(), 1, 1'b1), 1'b0);
        for (int k = 0; k < SORT_DEPTH + 1; k++)
            queue_record(build_record(64'(100 - k), rand64(), 0, 0, 0, 0, 0, 0, 64'(k),
                                      k == SORT_DEPTH), 1'b0);

        random_items = 0;
        set_index = 0;
        prev = '0;
        while (random_items < 500)
        begin
            case ($urandom_range(0, 9))
                0: set_len = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 8);
                1: set_len = SORT_DEPTH;
                default: set_len = $urandom_range(1, SORT_DEPTH - 1);
            endcase
            for (int k = 0; k < set_len; k++)
            begin
                h0 = pick_word();
                h1 = pick_word();
                h2 = pick_word();
                h3 = pick_word();
                r0 = pick_word();
                r1 = pick_word();
                r2 = pick_word();
                r3 = pick_word();
                if (k > 0 && $urandom_range(0, 2) == 0)
                begin
                    {h0, h1, h2, h3} = {prev.hash_word_0, prev.hash_word_1,
                                        prev.hash_word_2, prev.hash_word_3};
                    if ($urandom_range(0, 1) == 0)
                        {r0, r1, r2, r3} = {prev.ref_word_0, prev.ref_word_1,
                                            prev.ref_word_2, prev.ref_word_3};
                end
                prev = build_record(h0, h1, h2, h3, r0, r1, r2, r3, pick_word(),
                                    k == set_len - 1);
                queue_record(prev, k == 0 && set_index % 10 == 0);
                random_items++;
            end
            set_index++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (send_queue.size() != 0 || start || sorted_expect.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Accepted %0d records in %0d sets (%0d with dropped records),",
                 accepted_count, sets_drained, overflow_sets);
        $display("checked %0d sorted beats.", results_checked);
        if (mismatch_count == 0 && sorted_expect.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
